// ===== design/dqe_pkg.sv =====
// Package with the item types, command codes and status codes of the double-ended queue.
`default_nettype none
package dqe_pkg;

    // Widths fixed by the item format.
    localparam int CMD_W    = 3;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;

    // Default queue depth.
    localparam int DEPTH_DEF = 16;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SWAP       = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ_BF    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ_FB    = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // One input item.
    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic signed [DATA_W-1:0] value;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic                     last;
        logic [STATUS_W-1:0]      status;
    } out_item_t;

endpackage
`default_nettype wire

// ===== design/double_ended_queue_engine.sv =====
// Top level of the double-ended queue engine: command sequencer, indexes and result register.
//
//   channel   ports                    direction   payload
//   input     s_valid s_ready s_item   in          in_item_t  (cmd, value)
//   result    m_valid m_ready m_item   out         out_item_t (data, last, status)
//
// Pushes, rejected pushes, empty-queue results and unused commands are handled in S_IDLE.
// A swap reads the front and then the back (registered read), then writes each into the
// other's slot. A readout reads each entry from the store (registered read) before it
// is loaded into the result register.
// Reset empties the queue at once; the entries themselves are not cleared.
// A stalled result holds the sequencer; a new item is taken only when it is idle
// and the result register is free or being emptied.
`default_nettype none
module double_ended_queue_engine #(
    parameter int DEPTH = dqe_pkg::DEPTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire dqe_pkg::in_item_t  s_item,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output dqe_pkg::out_item_t      m_item
);
    import dqe_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SW_RB,
        S_SW_WA,
        S_SW_WB,
        S_READ,
        S_LOAD
    } state_t;

    state_t                   state_reg;
    logic [IW-1:0]            head_reg;
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            idx_reg;
    logic                     back_first_reg;
    logic signed [DATA_W-1:0] tmp_reg;
    logic                     m_valid_reg;
    out_item_t                m_item_reg;

    logic                     wr_en;
    logic [IW-1:0]            wr_addr;
    logic signed [DATA_W-1:0] wr_data;
    logic                     rd_en;
    logic [IW-1:0]            rd_addr;
    logic signed [DATA_W-1:0] rd_data;

    logic                     out_free;
    logic                     out_load;
    logic                     accept;
    logic                     full;
    logic                     empty;
    logic [IW-1:0]            head_dec;
    logic [CW-1:0]            stream_off;
    logic                     stream_last;

    // Circular slot of an offset from the front; the sum stays below twice the depth.
    function automatic logic [IW-1:0] slot(input logic [IW-1:0] head, input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = {{(CW + 1 - IW){1'b0}}, head} + {1'b0, off};
        if (sum >= (CW + 1)'(DEPTH)) begin
            sum = sum - (CW + 1)'(DEPTH);
        end
        return sum[IW-1:0];
    endfunction

    // Handshake and queue flags.
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_dec = (head_reg == '0) ? IW'(DEPTH - 1) : head_reg - IW'(1);

    // Readout position: from the back or from the front.
    assign stream_off  = back_first_reg ? (count_reg - CW'(1) - idx_reg) : idx_reg;
    assign stream_last = (idx_reg + CW'(1) == count_reg);

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // A result item is loaded into the result register this cycle.
    always_comb begin
        out_load = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (s_item.cmd)
                        CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
                            out_load = 1'b1;
                        end
                        CMD_SWAP, CMD_READ_BF, CMD_READ_FB: begin
                            out_load = empty;
                        end
                        default: begin
                            out_load = 1'b0;
                        end
                    endcase
                end
            end
            S_SW_WB, S_LOAD: begin
                out_load = out_free;
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    // Store port control for each step of the sequencer.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = slot(head_reg, count_reg);
        wr_data = s_item.value;
        rd_en   = 1'b0;
        rd_addr = slot(head_reg, '0);
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (s_item.cmd)
                        CMD_PUSH_BACK: begin
                            wr_en = !full;
                        end
                        CMD_PUSH_FRONT: begin
                            wr_en   = !full;
                            wr_addr = head_dec;
                        end
                        CMD_SWAP: begin
                            rd_en = !empty;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SW_RB: begin
                rd_en   = 1'b1;
                rd_addr = slot(head_reg, count_reg - CW'(1));
            end
            S_SW_WA: begin
                wr_en   = 1'b1;
                wr_addr = slot(head_reg, '0);
                wr_data = rd_data;
            end
            S_SW_WB: begin
                wr_en   = out_free;
                wr_addr = slot(head_reg, count_reg - CW'(1));
                wr_data = tmp_reg;
            end
            S_READ: begin
                rd_en   = 1'b1;
                rd_addr = slot(head_reg, stream_off);
            end
            default: begin
            end
        endcase
    end

    dqe_store #(
        .DEPTH (DEPTH),
        .ADDR_W(IW)
    ) u_store (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // Sequencer, queue indexes and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && !out_load) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        m_item_reg.data <= '0;
                        m_item_reg.last <= 1'b1;
                        case (s_item.cmd)
                            CMD_PUSH_BACK: begin
                                m_valid_reg <= 1'b1;
                                if (full) begin
                                    m_item_reg.status <= ST_FULL;
                                end else begin
                                    count_reg         <= count_reg + CW'(1);
                                    m_item_reg.status <= ST_OK;
                                end
                            end
                            CMD_PUSH_FRONT: begin
                                m_valid_reg <= 1'b1;
                                if (full) begin
                                    m_item_reg.status <= ST_FULL;
                                end else begin
                                    head_reg          <= head_dec;
                                    count_reg         <= count_reg + CW'(1);
                                    m_item_reg.status <= ST_OK;
                                end
                            end
                            CMD_SWAP: begin
                                if (empty) begin
                                    m_valid_reg       <= 1'b1;
                                    m_item_reg.status <= ST_EMPTY;
                                end else begin
                                    state_reg <= S_SW_RB;
                                end
                            end
                            CMD_READ_BF, CMD_READ_FB: begin
                                if (empty) begin
                                    m_valid_reg       <= 1'b1;
                                    m_item_reg.status <= ST_EMPTY;
                                end else begin
                                    back_first_reg <= (s_item.cmd == CMD_READ_BF);
                                    idx_reg        <= '0;
                                    state_reg      <= S_READ;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SW_RB: begin
                    // Front value has arrived; hold it while the back is read.
                    tmp_reg   <= rd_data;
                    state_reg <= S_SW_WA;
                end
                S_SW_WA: begin
                    state_reg <= S_SW_WB;
                end
                S_SW_WB: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_item_reg  <= '{data: '0, last: 1'b1, status: ST_OK};
                        state_reg   <= S_IDLE;
                    end
                end
                S_READ: begin
                    state_reg <= S_LOAD;
                end
                S_LOAD: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_item_reg  <= '{data: rd_data, last: stream_last, status: ST_OK};
                        if (stream_last) begin
                            state_reg <= S_IDLE;
                        end else begin
                            idx_reg   <= idx_reg + CW'(1);
                            state_reg <= S_READ;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== design/dqe_store.sv =====
// Entry store of the queue: one write port and one read port with registered read data.
`default_nettype none
module dqe_store #(
    parameter int DEPTH  = dqe_pkg::DEPTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic                             aclk,
    input  wire logic                             wr_en,
    input  wire logic [ADDR_W-1:0]                wr_addr,
    input  wire logic signed [dqe_pkg::DATA_W-1:0] wr_data,
    input  wire logic                             rd_en,
    input  wire logic [ADDR_W-1:0]                rd_addr,
    output logic signed [dqe_pkg::DATA_W-1:0]      rd_data
);
    import dqe_pkg::*;

    logic signed [DATA_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== tb/double_ended_queue_engine_tb.sv =====
// Testbench for the double-ended queue engine: directed and random commands against a predictor.
module double_ended_queue_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dqe_pkg::*;

    localparam int DEPTH        = DEPTH_DEF;
    localparam int IDX_W        = $clog2(DEPTH);
    localparam int RANDOM_ITEMS = 350;
    localparam int QUIET_ITEMS  = 50;
    localparam int HOLD_AFTER   = 60;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 400000;

    // Command codes that the block ignores.
    localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = 3'd5;
    localparam logic [CMD_W-1:0] CMD_MID_UNUSED   = 3'd6;
    localparam logic [CMD_W-1:0] CMD_LAST_UNUSED  = 3'd7;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    // Predictor state: the deque as the block should hold it.
    logic signed [DATA_W-1:0] dq_store [DEPTH];
    logic [IDX_W-1:0]         dq_head  = '0;
    logic [IDX_W:0]           dq_count = '0;

    in_item_t  queued_commands[$];
    out_item_t awaited_results[$];

    int   items_taken = 0;
    int   mismatches  = 0;
    int   cycle_count = 0;
    int   send_gap    = 0;
    int   stall_left  = 0;
    int   hold_left   = 0;
    logic held_once   = 1'b0;
    logic quiet_tail  = 1'b0;

    double_ended_queue_engine #(.DEPTH(DEPTH)) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #6 aclk = ~aclk;

    // Store position of the entry at a given offset from the front.
    function automatic logic [IDX_W-1:0] slot_of(input int unsigned off);
        return IDX_W'((dq_head + off) % DEPTH);
    endfunction

    // Update the deque for one accepted command and queue the results it causes.
    task automatic apply_deque_command(input in_item_t cmd_item);
        out_item_t                res;
        logic [IDX_W-1:0]         front_pos;
        logic [IDX_W-1:0]         back_pos;
        logic signed [DATA_W-1:0] held;
        int unsigned              off;
        res      = '0;
        res.last = 1'b1;
        case (cmd_item.cmd)
            CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
                if (dq_count == DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    if (cmd_item.cmd == CMD_PUSH_BACK) begin
                        dq_store[slot_of(dq_count)] = cmd_item.value;
                    end else begin
                        dq_head = IDX_W'((dq_head + DEPTH - 1) % DEPTH);
                        dq_store[dq_head] = cmd_item.value;
                    end
                    dq_count = dq_count + 1'b1;
                    res.status = ST_OK;
                end
                awaited_results.push_back(res);
            end
            CMD_SWAP: begin
                if (dq_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    front_pos = slot_of(0);
                    back_pos  = slot_of(dq_count - 1);
                    held                = dq_store[front_pos];
                    dq_store[front_pos] = dq_store[back_pos];
                    dq_store[back_pos]  = held;
                    res.status = ST_OK;
                end
                awaited_results.push_back(res);
            end
            CMD_READ_BF, CMD_READ_FB: begin
                if (dq_count == 0) begin
                    res.status = ST_EMPTY;
                    awaited_results.push_back(res);
                end else begin
                    for (int k = 0; k < dq_count; k++) begin
                        off = (cmd_item.cmd == CMD_READ_BF) ? dq_count - 1 - k : k;
                        res.data   = dq_store[slot_of(off)];
                        res.last   = (k == dq_count - 1);
                        res.status = ST_OK;
                        awaited_results.push_back(res);
                    end
                end
            end
            default: begin
                // Unused codes leave the deque alone and produce nothing.
            end
        endcase
    endtask

    task automatic add_command(input logic [CMD_W-1:0] cmd,
                               input logic signed [DATA_W-1:0] value);
        in_item_t it;
        it.cmd   = cmd;
        it.value = value;
        queued_commands.push_back(it);
    endtask

    // Picks one of the command codes that the block ignores.
    function automatic logic [CMD_W-1:0] CMD_LOGIC_UNUSED_PICK();
        return CMD_W'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED));
    endfunction

    // Driver: offers queued items, with random idle bursts outside the final stretch.
    always @(posedge aclk) begin : drive_items
        logic offer;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            offer = s_valid;
            if (s_valid && s_ready) begin
                apply_deque_command(s_item);
                items_taken++;
                offer = 1'b0;
            end
            if (!offer) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (queued_commands.size() > 0) begin
                    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                        send_gap = $urandom_range(0, 9);
                    end else begin
                        s_item <= queued_commands.pop_front();
                        offer = 1'b1;
                    end
                end
            end
            s_valid <= offer;
            if (queued_commands.size() <= QUIET_ITEMS) begin
                quiet_tail <= 1'b1;
            end
        end
    end

    // Monitor: checks each result item and paces m_ready, with one long hold-off.
    always @(posedge aclk) begin : watch_results
        out_item_t want;
        logic      ready_next;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected item data=%0d last=%0b status=%0d", $time,
                             m_item.data, m_item.last, m_item.status);
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    if (m_item.data !== want.data || m_item.last !== want.last ||
                        m_item.status !== want.status) begin
                        $display("%0t: mismatch expected data=%0d last=%0b status=%0d",
                                 $time, want.data, want.last, want.status);
                        $display("%0t:          actual   data=%0d last=%0b status=%0d",
                                 $time, m_item.data, m_item.last, m_item.status);
                        mismatches++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else if (!held_once && items_taken >= HOLD_AFTER) begin
                held_once  = 1'b1;
                hold_left  = HOLD_CYCLES;
                ready_next = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                ready_next = 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 9);
                ready_next = 1'b0;
            end else begin
                ready_next = 1'b1;
            end
            m_ready <= ready_next;
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin : stimulus
        int pick;
        int made;
        for (int i = 0; i < DEPTH; i++) begin
            dq_store[i] = '0;
        end

        // Empty-queue cases, then a single entry.
        add_command(CMD_READ_BF, 32'sd0);
        add_command(CMD_READ_FB, 32'sd0);
        add_command(CMD_SWAP, 32'sd0);
        add_command(CMD_PUSH_FRONT, 32'sh7fffffff);
        add_command(CMD_SWAP, 32'sd0);
        add_command(CMD_READ_FB, 32'sd0);
        // A few entries at the value extremes, swapped and read back to front.
        add_command(CMD_PUSH_BACK, 32'sh80000000);
        add_command(CMD_PUSH_BACK, 32'sd0);
        add_command(CMD_PUSH_FRONT, -32'sd1);
        add_command(CMD_SWAP, 32'sd0);
        add_command(CMD_READ_BF, 32'sd0);
        add_command(CMD_FIRST_UNUSED, 32'sh5a5a5a5a);
        add_command(CMD_MID_UNUSED, 32'sh12345678);
        add_command(CMD_LAST_UNUSED, -32'sd1);
        // Fill the queue, then push into a full queue from both ends.
        while (queued_commands.size() < 14 + DEPTH - 4) begin
            add_command($urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT,
                        $signed($urandom()));
        end
        add_command(CMD_PUSH_BACK, 32'sh55555555);
        add_command(CMD_PUSH_FRONT, 32'shaaaaaaaa);
        add_command(CMD_READ_FB, 32'sd0);
        add_command(CMD_READ_BF, 32'sd0);

        // Random commands; ignored codes are sprinkled in but not counted.
        made = 0;
        while (made < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                add_command(CMD_PUSH_BACK, $signed($urandom()));
            end else if (pick < 30) begin
                add_command(CMD_PUSH_FRONT, $signed($urandom()));
            end else if (pick < 48) begin
                add_command(CMD_SWAP, $signed($urandom()));
            end else if (pick < 72) begin
                add_command(CMD_READ_BF, $signed($urandom()));
            end else if (pick < 96) begin
                add_command(CMD_READ_FB, $signed($urandom()));
            end else begin
                add_command(CMD_LOGIC_UNUSED_PICK(), $signed($urandom()));
                made--;
            end
            made++;
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait for all items to go in and all results to come out.
        while (queued_commands.size() != 0 || s_valid) @(posedge aclk);
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0 && awaited_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
